/* hw/rtl/bsg_pkg.sv */
package bsg_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int OFFSET_W = 48;
    localparam int SUM_W    = 16;
    localparam int HASH_W   = 64;

    localparam logic [LEN_W-1:0]  LEN_RESET = 13'd2048;
    localparam logic [LEN_W-1:0]  LEN_MAX   = 13'd4096;
    localparam logic [LEN_W-1:0]  LEN_MIN   = 13'd1;
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] block_offset;
        logic [31:0]         weak_sum;
        logic [HASH_W-1:0]   fnv_hash;
        logic                final_block;
    } out_item_t;

    // x * 0x100000001b3 mod 2^64 as a shift-add tree
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        if (len == '0)
            eff_length = LEN_MIN;
        else if (len > LEN_MAX)
            eff_length = LEN_MAX;
        else
            eff_length = len;
    endfunction

endpackage

/* hw/rtl/bsg_in_reg.sv */
module bsg_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bsg_pkg::in_item_t in_data,
    output logic              item_valid,
    input  logic              item_take,
    output bsg_pkg::in_item_t item_data
);
    import bsg_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

/* hw/rtl/bsg_block_accum.sv */
module bsg_block_accum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_enable,
    input  logic [bsg_pkg::LEN_W-1:0]   cfg_write_data,
    input  logic                        item_fire,
    input  bsg_pkg::in_item_t           item_data,
    output logic                        result_load,
    output bsg_pkg::out_item_t          result_data
);
    import bsg_pkg::*;

    logic [LEN_W-1:0]    len_reg;
    logic [SUM_W-1:0]    sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]    sum_b_reg, sum_b_next;
    logic [HASH_W-1:0]   fnv_reg, fnv_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [OFFSET_W-1:0] start_reg, start_next;

    logic [SUM_W-1:0]  a_upd;
    logic [SUM_W-1:0]  b_upd;
    logic [HASH_W-1:0] fnv_upd;
    logic [LEN_W-1:0]  count_upd;
    logic              close;

    always_comb
    begin
        a_upd     = sum_a_reg + SUM_W'(item_data.data_byte);
        b_upd     = sum_b_reg + a_upd;
        fnv_upd   = fnv_mul(fnv_reg ^ HASH_W'(item_data.data_byte));
        count_upd = count_reg + LEN_W'(1);
        close     = (count_upd >= eff_length(len_reg)) || item_data.end_of_file;

        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        fnv_next   = fnv_reg;
        count_next = count_reg;
        start_next = start_reg;

        if (item_fire)
        begin
            if (close)
            begin
                sum_a_next = '0;
                sum_b_next = '0;
                fnv_next   = FNV_BASIS;
                count_next = '0;
                if (item_data.end_of_file)
                    start_next = '0;
                else
                    start_next = start_reg + OFFSET_W'(count_upd);
            end
            else
            begin
                sum_a_next = a_upd;
                sum_b_next = b_upd;
                fnv_next   = fnv_upd;
                count_next = count_upd;
            end
        end
    end

    assign result_load              = item_fire && close;
    assign result_data.block_offset = start_reg;
    assign result_data.weak_sum     = {b_upd, a_upd};
    assign result_data.fnv_hash     = fnv_upd;
    assign result_data.final_block  = item_data.end_of_file;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RESET;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            fnv_reg   <= FNV_BASIS;
            count_reg <= '0;
            start_reg <= '0;
        end
        else
        begin
            if (cfg_write_enable)
                len_reg <= cfg_write_data;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            fnv_reg   <= fnv_next;
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

endmodule

/* hw/rtl/bsg_out_reg.sv */
module bsg_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bsg_pkg::out_item_t load_data,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output bsg_pkg::out_item_t out_data
);
    import bsg_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/block_signature_generator_unit.sv */
// Block signature generator: takes one file byte per transaction and emits one
// signature per block (rsync weak sums a/b and FNV-1a 64) when the block reaches
// block_length bytes (0 acts as 1, above 4096 acts as 4096) or the byte carries
// end_of_file, which also returns the offset to 0. Sustained rate is one byte per
// cycle while no finished signature is held back; a block's last byte passes
// through the input register, then the per-byte sum and shift-add FNV update,
// into the result register, where its signature becomes visible. The input side
// stalls only while a finished signature is held.
module block_signature_generator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_enable,
    input  logic [bsg_pkg::LEN_W-1:0]   cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  bsg_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bsg_pkg::out_item_t          out_data
);
    import bsg_pkg::*;

    logic      item_valid;
    logic      item_fire;
    in_item_t  item_data;
    logic      result_load;
    out_item_t result_data;
    logic      can_load;

    assign item_fire = item_valid && can_load;

    bsg_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_take  (item_fire),
        .item_data  (item_data)
    );

    bsg_block_accum u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .item_fire        (item_fire),
        .item_data        (item_data),
        .result_load      (result_load),
        .result_data      (result_data)
    );

    bsg_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (result_load),
        .load_data (result_data),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsg_pkg::*;

    localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
    localparam int QUIET_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write_enable = 1'b0;
    logic [LEN_W-1:0] cfg_write_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;

    in_item_t  pending_bytes[$];
    out_item_t expected_sigs[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit in_taken       = 1'b0;
    int errors         = 0;
    int bytes_in       = 0;
    int sigs_checked   = 0;
    int eofs_seen      = 0;
    int settings       = 0;
    int quiet_count    = 0;

    // predicted block state
    logic [LEN_W-1:0]    len_reg   = LEN_RESET;
    logic [SUM_W-1:0]    sum_a     = '0;
    logic [SUM_W-1:0]    sum_b     = '0;
    logic [HASH_W-1:0]   fnv       = FNV_BASIS;
    logic [LEN_W-1:0]    fill      = '0;
    logic [OFFSET_W-1:0] start_off = '0;

    int lengths[12] = '{3, 1, 0, 16, 4096, 2, 8191, 7, 300, 4097, 5, 64};

    block_signature_generator_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch at signature %0d: %s got %h expected %h",
                 sigs_checked, field, got, want);
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eof);
        in_item_t t;
        t.data_byte   = b;
        t.end_of_file = eof;
        pending_bytes = {pending_bytes, t};
    endtask

    // eof_odds of 0 means no end of file in the run
    task automatic queue_file_bytes(input int count, input int eof_odds);
        in_item_t t;
        for (int i = 0; i < count; i++)
        begin
            t.data_byte   = BYTE_W'($urandom_range(255));
            t.end_of_file = (eof_odds > 0) && ($urandom_range(eof_odds - 1) == 0);
            pending_bytes = {pending_bytes, t};
        end
    endtask

    // checked at the rising edge, where queue and valid are stable
    task automatic wait_quiet();
        @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_sigs.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        wait_quiet();
        @(negedge clk);
        cfg_write_data   <= len;
        cfg_write_enable <= 1'b1;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        settings++;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && !in_taken))
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // predictor and monitor
    always @(posedge clk)
    begin : predict
        out_item_t        sig;
        logic [LEN_W-1:0] limit;
        in_taken = in_valid && in_ready;
        if (rst_n && cfg_write_enable)
            len_reg = cfg_write_data;
        if (rst_n && in_taken)
        begin
            bytes_in++;
            sum_a = sum_a + SUM_W'(in_data.data_byte);
            sum_b = sum_b + sum_a;
            fnv   = (fnv ^ HASH_W'(in_data.data_byte)) * FNV_PRIME;
            fill  = fill + LEN_W'(1);
            if (len_reg == '0)
                limit = LEN_MIN;
            else if (len_reg > LEN_MAX)
                limit = LEN_MAX;
            else
                limit = len_reg;
            if (fill >= limit || in_data.end_of_file)
            begin
                sig.block_offset = start_off;
                sig.weak_sum     = {sum_b, sum_a};
                sig.fnv_hash     = fnv;
                sig.final_block  = in_data.end_of_file;
                expected_sigs    = {expected_sigs, sig};
                start_off = in_data.end_of_file ? '0 : start_off + OFFSET_W'(fill);
                sum_a = '0;
                sum_b = '0;
                fnv   = FNV_BASIS;
                fill  = '0;
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_sigs.size() == 0)
                report_mismatch("unexpected transaction, offset",
                                64'(out_data.block_offset), '0);
            else
            begin
                sig = expected_sigs.pop_front();
                if (out_data.block_offset !== sig.block_offset)
                    report_mismatch("block_offset", 64'(out_data.block_offset),
                                    64'(sig.block_offset));
                if (out_data.weak_sum !== sig.weak_sum)
                    report_mismatch("weak_sum", 64'(out_data.weak_sum),
                                    64'(sig.weak_sum));
                if (out_data.fnv_hash !== sig.fnv_hash)
                    report_mismatch("fnv_hash", out_data.fnv_hash, sig.fnv_hash);
                if (out_data.final_block !== sig.final_block)
                    report_mismatch("final_block", 64'(out_data.final_block),
                                    64'(sig.final_block));
            end
            sigs_checked++;
            if (out_data.final_block === 1'b1)
                eofs_seen++;
        end
    end

    // watchdog: cycles with work outstanding but no transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (pending_bytes.size() == 0 && !in_valid && expected_sigs.size() == 0))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset length, short files and single-byte files
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'haa, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        // zero length acts as one
        set_length(13'd0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'hfe, 1'b0);
        push_byte(8'h55, 1'b1);
        set_length(LEN_MIN);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b1);
        // open a block under an oversized length, then shrink it
        set_length(13'd4097);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b0);
        set_length(13'd2);
        push_byte(8'h40, 1'b0);
        push_byte(8'h50, 1'b0);
        push_byte(8'h60, 1'b1);

        for (int p = 0; p < 12; p++)
        begin
            set_length(LEN_W'(lengths[p]));
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            queue_file_bytes(24, 10);
        end

        // one long saturated-length block of 0xff, both sums wrap
        set_length(13'h1fff);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 260; i++)
            push_byte(8'hff, 1'b0);
        push_byte(8'hff, 1'b1);

        wait_quiet();
        $display("%0d bytes sent over %0d length settings, idle and stall rates 0 to 80%%",
                 bytes_in, settings);
        $display("%0d signatures compared, %0d of them at end of file", sigs_checked, eofs_seen);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
